// ----- rtl/core/hsmc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Heater sleep mode controller package
// Shared types, codes and sizes for the mode controller and its submodules.
// ============================================================================
package hsmc_pkg;

    // Field widths.
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned TEMP_W  = 10;
    localparam int unsigned VALUE_W = 11;
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned KIND_W  = 2;

    // Configuration port geometry.
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;

    // Result queue depth; must be a power of two and at least two.
    localparam int unsigned OUTQ_DEPTH = 4;

    // Operating modes, coded as they appear in mode notices.
    typedef enum logic [1:0] {
        MODE_WORKING = 2'd0,
        MODE_STANDBY = 2'd1,
        MODE_IDLE    = 2'd2,
        MODE_BOOST   = 2'd3
    } mode_t;

    // Request codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK        = 3'd0,
        FUNC_EVALUATE    = 3'd1,
        FUNC_MOTION      = 3'd2,
        FUNC_WORK_TOGGLE = 3'd3,
        FUNC_BOOST_TOGGLE = 3'd4,
        FUNC_SET_TEMP    = 3'd5,
        FUNC_READ_TEMP   = 3'd6
    } func_t;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_HEATER = 2'd0,
        KIND_MODE   = 2'd1,
        KIND_REPORT = 2'd2
    } kind_t;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_STANDBY_TIMEOUT = 3'd0,
        REG_IDLE_TIMEOUT    = 3'd1,
        REG_BOOST_TIMEOUT   = 3'd2,
        REG_STANDBY_TEMP    = 3'd3,
        REG_BOOST_INCREMENT = 3'd4
    } reg_index_t;

    // Configuration register contents.
    typedef struct packed {
        logic [TIME_W-1:0] standby_timeout_ms;
        logic [TIME_W-1:0] idle_timeout_ms;
        logic [TIME_W-1:0] boost_timeout_ms;
        logic [TEMP_W-1:0] standby_temperature;
        logic [TEMP_W-1:0] boost_increment;
    } cfg_t;

    // One result item.
    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } res_t;

    // Results produced by one request, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } res_pair_t;

    // Build a result item that is not yet marked as last.
    function automatic res_t make_res(kind_t kind, logic [VALUE_W-1:0] value);
        res_t r;
        r.kind  = kind;
        r.value = value;
        r.last  = 1'b0;
        return r;
    endfunction

    // Mode code widened to the value field.
    function automatic logic [VALUE_W-1:0] mode_value(mode_t m);
        return {{(VALUE_W-2){1'b0}}, m};
    endfunction

    // Temperature widened to the value field.
    function automatic logic [VALUE_W-1:0] temp_value(logic [TEMP_W-1:0] t);
        return {{(VALUE_W-TEMP_W){1'b0}}, t};
    endfunction

endpackage

// ----- rtl/core/hsmc_regs.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Configuration register file
// APB-style slave holding the timeouts, standby temperature and boost step.
// ============================================================================
module hsmc_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hsmc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hsmc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hsmc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output hsmc_pkg::cfg_t                  cfg
);
    import hsmc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign index  = reg_index_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_STANDBY_TIMEOUT: cfg_reg.standby_timeout_ms  <= pwdata[TIME_W-1:0];
                REG_IDLE_TIMEOUT:    cfg_reg.idle_timeout_ms     <= pwdata[TIME_W-1:0];
                REG_BOOST_TIMEOUT:   cfg_reg.boost_timeout_ms    <= pwdata[TIME_W-1:0];
                REG_STANDBY_TEMP:    cfg_reg.standby_temperature <= pwdata[TEMP_W-1:0];
                REG_BOOST_INCREMENT: cfg_reg.boost_increment     <= pwdata[TEMP_W-1:0];
                default:             ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        prdata = '0;
        unique case (index)
            REG_STANDBY_TIMEOUT: prdata = cfg_reg.standby_timeout_ms;
            REG_IDLE_TIMEOUT:    prdata = cfg_reg.idle_timeout_ms;
            REG_BOOST_TIMEOUT:   prdata = cfg_reg.boost_timeout_ms;
            REG_STANDBY_TEMP:    prdata = {{(APB_DATA_W-TEMP_W){1'b0}}, cfg_reg.standby_temperature};
            REG_BOOST_INCREMENT: prdata = {{(APB_DATA_W-TEMP_W){1'b0}}, cfg_reg.boost_increment};
            default:             prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/hsmc_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Mode controller core
// Input register, mode state and the single-pass request evaluation.
// ============================================================================
module hsmc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hsmc_pkg::FUNC_W-1:0] in_func,
    input  logic [hsmc_pkg::TEMP_W-1:0] in_temp,
    input  hsmc_pkg::cfg_t              cfg,
    input  logic                        room,
    output hsmc_pkg::res_pair_t         res
);
    import hsmc_pkg::*;

    // Input register.
    logic              in_valid_reg;
    func_t             func_reg;
    logic [TEMP_W-1:0] temp_reg;

    // Controller state.
    mode_t             mode_reg,        mode_next;
    logic [TIME_W-1:0] now_ms_reg,      now_ms_next;
    logic [TIME_W-1:0] motion_ms_reg,   motion_ms_next;
    logic [TIME_W-1:0] boost_ms_reg,    boost_ms_next;
    logic [TEMP_W-1:0] work_temp_reg,   work_temp_next;

    logic              fire;
    logic [TIME_W-1:0] since_motion;
    logic [TIME_W-1:0] since_boost;
    logic [VALUE_W-1:0] boost_temp;
    res_pair_t         pair;

    // A held request is evaluated once the result queue has room for two.
    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg <= func_t'(in_func);
            temp_reg <= in_temp;
        end
    end

    // State registers advance only when a request is evaluated.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            now_ms_reg    <= '0;
            motion_ms_reg <= '0;
            boost_ms_reg  <= '0;
            work_temp_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            now_ms_reg    <= now_ms_next;
            motion_ms_reg <= motion_ms_next;
            boost_ms_reg  <= boost_ms_next;
            work_temp_reg <= work_temp_next;
        end
    end

    // Elapsed times wrap modulo 2^32.
    assign since_motion = now_ms_reg - motion_ms_reg;
    assign since_boost  = now_ms_reg - boost_ms_reg;
    assign boost_temp   = temp_value(work_temp_reg) + temp_value(cfg.boost_increment);

    // Next state and the results of the held request.
    always_comb
    begin
        mode_next      = mode_reg;
        now_ms_next    = now_ms_reg;
        motion_ms_next = motion_ms_reg;
        boost_ms_next  = boost_ms_reg;
        work_temp_next = work_temp_reg;
        pair           = '0;

        unique case (func_reg)
            FUNC_TICK:
            begin
                now_ms_next = now_ms_reg + 1'b1;
            end
            FUNC_EVALUATE:
            begin
                unique case (mode_reg)
                    MODE_WORKING:
                    begin
                        if (since_motion > cfg.standby_timeout_ms)
                        begin
                            mode_next   = MODE_STANDBY;
                            pair.count  = 2'd2;
                            pair.first  = make_res(KIND_HEATER,
                                                   temp_value(cfg.standby_temperature));
                            pair.second = make_res(KIND_MODE, mode_value(MODE_STANDBY));
                        end
                    end
                    MODE_STANDBY:
                    begin
                        if (since_motion > cfg.idle_timeout_ms)
                        begin
                            mode_next  = MODE_IDLE;
                            pair.count = 2'd1;
                            pair.first = make_res(KIND_MODE, mode_value(MODE_IDLE));
                        end
                        else if (since_motion < cfg.standby_timeout_ms)
                        begin
                            mode_next   = MODE_WORKING;
                            pair.count  = 2'd2;
                            pair.first  = make_res(KIND_HEATER, temp_value(work_temp_reg));
                            pair.second = make_res(KIND_MODE, mode_value(MODE_WORKING));
                        end
                    end
                    MODE_BOOST:
                    begin
                        // Boost expiry reports the mode only, with no heater target.
                        if (since_boost > cfg.boost_timeout_ms)
                        begin
                            mode_next  = MODE_WORKING;
                            pair.count = 2'd1;
                            pair.first = make_res(KIND_MODE, mode_value(MODE_WORKING));
                        end
                    end
                    MODE_IDLE:
                    begin
                    end
                endcase
            end
            FUNC_MOTION:
            begin
                motion_ms_next = now_ms_reg;
            end
            FUNC_WORK_TOGGLE:
            begin
                if (mode_reg == MODE_IDLE || mode_reg == MODE_STANDBY)
                begin
                    mode_next      = MODE_WORKING;
                    motion_ms_next = now_ms_reg;
                    pair.count     = 2'd2;
                    pair.first     = make_res(KIND_MODE, mode_value(MODE_WORKING));
                    pair.second    = make_res(KIND_HEATER, temp_value(work_temp_reg));
                end
                else
                begin
                    mode_next  = MODE_IDLE;
                    pair.count = 2'd1;
                    pair.first = make_res(KIND_MODE, mode_value(MODE_IDLE));
                end
            end
            FUNC_BOOST_TOGGLE:
            begin
                if (mode_reg == MODE_WORKING)
                begin
                    mode_next     = MODE_BOOST;
                    boost_ms_next = now_ms_reg;
                    pair.count    = 2'd2;
                    pair.first    = make_res(KIND_MODE, mode_value(MODE_BOOST));
                    pair.second   = make_res(KIND_HEATER, boost_temp);
                end
                else if (mode_reg == MODE_BOOST)
                begin
                    mode_next   = MODE_WORKING;
                    pair.count  = 2'd2;
                    pair.first  = make_res(KIND_MODE, mode_value(MODE_WORKING));
                    pair.second = make_res(KIND_HEATER, temp_value(work_temp_reg));
                end
            end
            FUNC_SET_TEMP:
            begin
                work_temp_next = temp_reg;
                if (mode_reg == MODE_WORKING)
                begin
                    pair.count = 2'd1;
                    pair.first = make_res(KIND_HEATER, temp_value(temp_reg));
                end
            end
            FUNC_READ_TEMP:
            begin
                pair.count = 2'd1;
                pair.first = make_res(KIND_REPORT, temp_value(work_temp_reg));
            end
            default:
            begin
            end
        endcase

        // Mark the final result of the request.
        if (pair.count == 2'd1)
        begin
            pair.first.last = 1'b1;
        end
        else if (pair.count == 2'd2)
        begin
            pair.second.last = 1'b1;
        end

        if (!fire)
        begin
            pair.count = 2'd0;
        end
    end

    assign res = pair;

endmodule

// ----- rtl/core/hsmc_outq.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Result queue
// Small register queue taking up to two results a cycle, giving out one while the output is ready.
// ============================================================================
module hsmc_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  hsmc_pkg::res_pair_t push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output hsmc_pkg::res_t      out_res
);
    import hsmc_pkg::*;

    localparam int unsigned PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned CNT_W = $clog2(OUTQ_DEPTH + 1);

    res_t             mem_reg [OUTQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= CNT_W'(OUTQ_DEPTH - 2));

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

endmodule

// ----- rtl/core/heater_sleep_mode_controller.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Heater sleep mode controller
// Top level: stream request port, APB configuration and result stream.
// ============================================================================
// A request is taken into an input register and evaluated, once the queue has
// room, in one pass against the mode state; its results, at most two, go into
// a four-entry result queue that drives the output stream one result per cycle
// while the stream is ready. Requests that cause at most one result then flow
// at one per cycle; requests that cause two results are limited by the
// single-result output port. Evaluation waits while the queue holds more than
// two results. Registers sit at byte addresses 0x00 standby timeout, 0x04 idle
// timeout, 0x08 boost timeout, 0x0C standby temperature, 0x10 boost increment;
// the user must write them only while no request is in flight (unenforced).
module heater_sleep_mode_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [9:0] temperature_value
    input  logic [2:0]                      s_axis_tuser,  // [2:0] func
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // [10:0] value
    output logic [1:0]                      m_axis_tuser,  // [1:0] kind
    output logic                            m_axis_tlast,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hsmc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hsmc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hsmc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import hsmc_pkg::*;

    cfg_t      cfg;
    res_pair_t pair;
    res_t      out_res;
    logic      room;

    hsmc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hsmc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_func  (s_axis_tuser),
        .in_temp  (s_axis_tdata[TEMP_W-1:0]),
        .cfg      (cfg),
        .room     (room),
        .res      (pair)
    );

    hsmc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pair),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Result packing onto the stream.
    assign m_axis_tdata = {{(16-VALUE_W){1'b0}}, out_res.value};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule
